### rtl/tirn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Telnet IAC receive negotiator - shared definitions
// Telnet command bytes, option codes, event codes, the descriptor of a burst
// of results and the opening negotiation table.
// ----------------------------------------------------------------------------
package tirn_pkg;

	localparam logic [7:0] B_IAC       = 8'hFF;
	localparam logic [7:0] B_DONT      = 8'hFE;
	localparam logic [7:0] B_DO        = 8'hFD;
	localparam logic [7:0] B_WONT      = 8'hFC;
	localparam logic [7:0] B_WILL      = 8'hFB;
	localparam logic [7:0] B_SB        = 8'hFA;
	localparam logic [7:0] B_SE        = 8'hF0;
	localparam logic [7:0] OPT_BIN     = 8'h00;
	localparam logic [7:0] TELOPT_ECHO = 8'h01;
	localparam logic [7:0] OPT_SGA     = 8'h03;

	localparam logic [1:0] KIND_BYTE       = 2'd0;
	localparam logic [1:0] KIND_CONNECT    = 2'd1;
	localparam logic [1:0] KIND_DISCONNECT = 2'd2;

	localparam int unsigned OPEN_LEN  = 12;
	localparam int unsigned REPLY_LEN = 3;
	localparam int unsigned IDX_W     = $clog2(OPEN_LEN);

	localparam logic DEST_APP    = 1'b0;
	localparam logic DEST_CLIENT = 1'b1;

	// Kind of result burst that one item causes.
	typedef enum logic [1:0] {
		BURST_NONE,
		BURST_DATA,
		BURST_REPLY,
		BURST_OPEN
	} burst_t;

	typedef struct packed {
		burst_t     kind;
		logic [7:0] val;   // data byte or option code
		logic [7:0] verb;  // reply verb (WONT or DONT)
	} desc_t;

	// Opening negotiation: IAC WILL ECHO, IAC WILL SGA, IAC WILL BINARY,
	// IAC DO BINARY.
	function automatic logic [7:0] open_byte(input logic [IDX_W-1:0] idx);
		logic [7:0] b;
		case (idx)
			4'd0:    b = B_IAC;
			4'd1:    b = B_WILL;
			4'd2:    b = TELOPT_ECHO;
			4'd3:    b = B_IAC;
			4'd4:    b = B_WILL;
			4'd5:    b = OPT_SGA;
			4'd6:    b = B_IAC;
			4'd7:    b = B_WILL;
			4'd8:    b = OPT_BIN;
			4'd9:    b = B_IAC;
			4'd10:   b = B_DO;
			4'd11:   b = OPT_BIN;
			default: b = B_IAC;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

### rtl/tirn_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Telnet IAC receive negotiator - input stage and parser
// Registers the accepted item, runs the telnet command parser on it and
// hands a burst descriptor to the result emitter.
// ----------------------------------------------------------------------------
module tirn_parser (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire  [1:0]           kind,
	input  wire  [7:0]           rx_byte,
	input  wire                  deliver_en,
	output logic                 desc_valid,
	output tirn_pkg::desc_t      desc,
	input  wire                  emit_ready
);

	typedef enum logic [2:0] {
		ST_DATA,
		ST_IAC,
		ST_WILL,
		ST_WONT,
		ST_DO,
		ST_DONT,
		ST_SB,
		ST_SB_IAC
	} state_t;

	state_t     state_q;
	state_t     state_d;
	logic       valid_s1;
	logic [1:0] kind_s1;
	logic [7:0] byte_s1;
	logic       advance;

	always_comb begin
		state_d   = state_q;
		desc.kind = tirn_pkg::BURST_NONE;
		desc.val  = byte_s1;
		desc.verb = tirn_pkg::B_DONT;
		if (kind_s1 == tirn_pkg::KIND_CONNECT) begin
			state_d   = ST_DATA;
			desc.kind = tirn_pkg::BURST_OPEN;
		end else if (kind_s1 == tirn_pkg::KIND_DISCONNECT) begin
			state_d = ST_DATA;
		end else if (kind_s1 == tirn_pkg::KIND_BYTE) begin
			case (state_q)
				ST_DATA: begin
					if (byte_s1 == tirn_pkg::B_IAC) begin
						state_d = ST_IAC;
					end else if (deliver_en) begin
						desc.kind = tirn_pkg::BURST_DATA;
					end
				end
				ST_IAC: begin
					case (byte_s1)
						tirn_pkg::B_IAC: begin
							state_d = ST_DATA;
							if (deliver_en) begin
								desc.kind = tirn_pkg::BURST_DATA;
							end
						end
						tirn_pkg::B_WILL: state_d = ST_WILL;
						tirn_pkg::B_WONT: state_d = ST_WONT;
						tirn_pkg::B_DO:   state_d = ST_DO;
						tirn_pkg::B_DONT: state_d = ST_DONT;
						tirn_pkg::B_SB:   state_d = ST_SB;
						default:          state_d = ST_DATA;
					endcase
				end
				ST_WILL: begin
					state_d = ST_DATA;
					if (byte_s1 != tirn_pkg::OPT_BIN) begin
						desc.kind = tirn_pkg::BURST_REPLY;
						desc.verb = tirn_pkg::B_DONT;
					end
				end
				ST_DO: begin
					state_d = ST_DATA;
					if (byte_s1 != tirn_pkg::TELOPT_ECHO && byte_s1 != tirn_pkg::OPT_SGA &&
					    byte_s1 != tirn_pkg::OPT_BIN) begin
						desc.kind = tirn_pkg::BURST_REPLY;
						desc.verb = tirn_pkg::B_WONT;
					end
				end
				ST_WONT, ST_DONT: state_d = ST_DATA;
				ST_SB: begin
					if (byte_s1 == tirn_pkg::B_IAC) begin
						state_d = ST_SB_IAC;
					end
				end
				default: begin
					state_d = (byte_s1 == tirn_pkg::B_SE) ? ST_DATA : ST_SB;
				end
			endcase
		end
	end

	// Items without results retire at once; others wait for the emitter.
	assign desc_valid = valid_s1 && (desc.kind != tirn_pkg::BURST_NONE);
	assign advance    = valid_s1 && ((desc.kind == tirn_pkg::BURST_NONE) || emit_ready);
	assign in_ready   = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_DATA;
			valid_s1 <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_d;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
				kind_s1  <= kind;
				byte_s1  <= rx_byte;
			end
		end
	end

	a_sb_silent: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && kind_s1 == tirn_pkg::KIND_BYTE && (state_q == ST_SB || state_q == ST_SB_IAC)
		|-> desc.kind == tirn_pkg::BURST_NONE)
		else $error("parser produced a result inside subnegotiation");

	a_connect_opens: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && kind_s1 == tirn_pkg::KIND_CONNECT |-> desc_valid &&
		desc.kind == tirn_pkg::BURST_OPEN)
		else $error("connect did not request the opening negotiation");

	a_event_resets: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (kind_s1 == tirn_pkg::KIND_CONNECT || kind_s1 == tirn_pkg::KIND_DISCONNECT)
		|=> state_q == ST_DATA)
		else $error("connect or disconnect did not return the parser to data");

	a_hold_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(state_q))
		else $error("blocked item was lost or parser state moved");

endmodule
`default_nettype wire

### rtl/tirn_emitter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Telnet IAC receive negotiator - result emitter
// Holds one burst descriptor and sends its bytes one transfer at a time.
// ----------------------------------------------------------------------------
module tirn_emitter (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  desc_valid,
	input  tirn_pkg::desc_t      desc,
	output logic                 emit_ready,
	output logic                 out_valid,
	input  wire                  out_ready,
	output logic [7:0]           out_byte,
	output logic                 out_dest,
	output logic                 out_last
);

	localparam int unsigned IDX_W = tirn_pkg::IDX_W;
	localparam logic [IDX_W-1:0] REPLY_END = IDX_W'(tirn_pkg::REPLY_LEN - 1);
	localparam logic [IDX_W-1:0] OPEN_END  = IDX_W'(tirn_pkg::OPEN_LEN - 1);

	logic                busy_q;
	tirn_pkg::burst_t    kind_q;
	logic [7:0]          val_q;
	logic [7:0]          verb_q;
	logic [IDX_W-1:0]    idx_q;
	logic                xfer;

	always_comb begin
		out_byte = val_q;
		out_dest = tirn_pkg::DEST_CLIENT;
		out_last = 1'b0;
		case (kind_q)
			tirn_pkg::BURST_DATA: begin
				out_dest = tirn_pkg::DEST_APP;
				out_last = 1'b1;
			end
			tirn_pkg::BURST_REPLY: begin
				out_last = (idx_q == REPLY_END);
				if (idx_q == '0) begin
					out_byte = tirn_pkg::B_IAC;
				end else if (idx_q == IDX_W'(1)) begin
					out_byte = verb_q;
				end
			end
			tirn_pkg::BURST_OPEN: begin
				out_last = (idx_q == OPEN_END);
				out_byte = tirn_pkg::open_byte(idx_q);
			end
			default: out_last = 1'b1;
		endcase
	end

	assign out_valid  = busy_q;
	assign xfer       = busy_q && out_ready;
	assign emit_ready = !busy_q || (out_ready && out_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			kind_q <= tirn_pkg::BURST_NONE;
			idx_q  <= '0;
		end else begin
			if (desc_valid && emit_ready) begin
				busy_q <= 1'b1;
				kind_q <= desc.kind;
				val_q  <= desc.val;
				verb_q <= desc.verb;
				idx_q  <= '0;
			end else if (xfer) begin
				if (out_last) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
		end
	end

	a_reply_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && kind_q == tirn_pkg::BURST_REPLY |-> idx_q <= REPLY_END)
		else $error("reply index past its end");

	a_open_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && kind_q == tirn_pkg::BURST_OPEN |-> idx_q <= OPEN_END)
		else $error("opening negotiation index past its end");

	a_data_single: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && kind_q == tirn_pkg::BURST_DATA |-> idx_q == '0 && out_last)
		else $error("data burst longer than one byte");

	a_busy_kind: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> kind_q != tirn_pkg::BURST_NONE)
		else $error("emitter busy with an empty burst");

endmodule
`default_nettype wire

### rtl/telnet_iac_receive_negotiator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Telnet IAC receive negotiator - top level
// Parses a telnet client byte stream, delivers data to the application and
// answers option negotiation toward the client.
// ----------------------------------------------------------------------------
// Each transfer on the input channel carries a received byte, a client
// connect or a client disconnect. The block accepts one item per cycle as
// long as each item causes at most one result and out_ready stays high: the
// item is registered, the parser decodes it against the current parser
// state, and the burst it causes is handed to a result register that is
// separate from the input register, so a new item enters while the
// previous result waits. A refused WILL or DO produces a three-byte reply
// (IAC DONT opt or IAC WONT opt) and a connect produces the twelve-byte
// opening negotiation; the result emitter sends these one byte per output
// transfer, so such an item holds the emitter until its last byte is sent
// and the input stalls behind it once its one-item input register is full.
// Items with no result (commands that are ignored, subnegotiation bytes,
// disconnects, data while delivery is off) retire without waiting for the
// emitter. Results toward the application have out_dest 0, replies to the
// client have out_dest 1, and out_last marks the final result of each item.
// The deliver_enable register, reset to 1, is written through cfg_wr_en and
// cfg_wr_data; the user, not the block, must keep writes to when it is idle.
// ----------------------------------------------------------------------------
module telnet_iac_receive_negotiator (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_wr_en,
	input  wire        cfg_wr_data,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire  [1:0] kind,
	input  wire  [7:0] rx_byte,
	output logic       out_valid,
	input  wire        out_ready,
	output logic [7:0] out_byte,
	output logic       out_dest,
	output logic       out_last
);

	// Delivery enable register; cleared data bytes are dropped but still parsed.
	logic            deliver_en_q;
	logic            desc_valid;
	logic            emit_ready;
	tirn_pkg::desc_t desc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deliver_en_q <= 1'b1;
		end else if (cfg_wr_en) begin
			deliver_en_q <= cfg_wr_data;
		end
	end

	// Input register and telnet command parser.
	tirn_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.rx_byte    (rx_byte),
		.deliver_en (deliver_en_q),
		.desc_valid (desc_valid),
		.desc       (desc),
		.emit_ready (emit_ready)
	);

	// Result register and byte sequencer for multi-byte bursts.
	tirn_emitter u_emitter (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_valid (desc_valid),
		.desc       (desc),
		.emit_ready (emit_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.out_dest   (out_dest),
		.out_last   (out_last)
	);

endmodule
`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Telnet IAC receive negotiator - testbench
// Feeds received bytes, connects and disconnects through the input handshake,
// predicts every emitted byte and its destination in a scoreboard class, and
// compares the emitted stream while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

	// Event code that the block must ignore.
	localparam logic [1:0] KIND_UNKNOWN = 2'd3;

	// Cycles to let pass after the last expected transfer. This covers items
	// that retire without a result and may still sit in the input register.
	localparam int QUIET_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 300;

	typedef enum logic [2:0] {
		PS_TEXT,
		PS_CMD,
		PS_WILL,
		PS_WONT,
		PS_DO,
		PS_DONT,
		PS_SUBNEG,
		PS_SUBNEG_CMD
	} parser_state_t;

	typedef struct packed {
		logic [7:0] data;
		logic       dest;
		logic       last;
	} emitted_t;

	// Tracks the parser and the delivery switch, and holds the bytes that the
	// block still owes, oldest first.
	class telnet_reply_scoreboard;
		emitted_t      owed_bytes[$];
		parser_state_t parser_state;
		bit            deliver_on;
		int            errors;

		function new();
			parser_state = PS_TEXT;
			deliver_on   = 1'b1;
			errors       = 0;
		endfunction

		function void set_delivery(bit on);
			deliver_on = on;
		endfunction

		function int pending();
			return owed_bytes.size();
		endfunction

		// Works out what one accepted item makes the block emit.
		function void accept_item(logic [1:0] ev, logic [7:0] value);
			emitted_t burst[$];
			logic [7:0] opts[3];
			opts = '{tirn_pkg::TELOPT_ECHO, tirn_pkg::OPT_SGA, tirn_pkg::OPT_BIN};
			if (ev == tirn_pkg::KIND_CONNECT) begin
				parser_state = PS_TEXT;
				foreach (opts[i]) begin
					burst.push_back('{tirn_pkg::B_IAC, tirn_pkg::DEST_CLIENT, 1'b0});
					burst.push_back('{tirn_pkg::B_WILL, tirn_pkg::DEST_CLIENT, 1'b0});
					burst.push_back('{opts[i], tirn_pkg::DEST_CLIENT, 1'b0});
				end
				burst.push_back('{tirn_pkg::B_IAC, tirn_pkg::DEST_CLIENT, 1'b0});
				burst.push_back('{tirn_pkg::B_DO, tirn_pkg::DEST_CLIENT, 1'b0});
				burst.push_back('{tirn_pkg::OPT_BIN, tirn_pkg::DEST_CLIENT, 1'b0});
			end else if (ev == tirn_pkg::KIND_DISCONNECT) begin
				parser_state = PS_TEXT;
			end else if (ev == tirn_pkg::KIND_BYTE) begin
				case (parser_state)
					PS_TEXT: begin
						if (value == tirn_pkg::B_IAC)
							parser_state = PS_CMD;
						else if (deliver_on)
							burst.push_back('{value, tirn_pkg::DEST_APP, 1'b0});
					end
					PS_CMD: begin
						parser_state = PS_TEXT;
						if (value == tirn_pkg::B_IAC) begin
							if (deliver_on)
								burst.push_back('{value, tirn_pkg::DEST_APP, 1'b0});
						end else if (value == tirn_pkg::B_WILL)
							parser_state = PS_WILL;
						else if (value == tirn_pkg::B_WONT)
							parser_state = PS_WONT;
						else if (value == tirn_pkg::B_DO)
							parser_state = PS_DO;
						else if (value == tirn_pkg::B_DONT)
							parser_state = PS_DONT;
						else if (value == tirn_pkg::B_SB)
							parser_state = PS_SUBNEG;
					end
					PS_WILL: begin
						if (value != tirn_pkg::OPT_BIN) begin
							burst.push_back('{tirn_pkg::B_IAC, tirn_pkg::DEST_CLIENT, 1'b0});
							burst.push_back('{tirn_pkg::B_DONT, tirn_pkg::DEST_CLIENT, 1'b0});
							burst.push_back('{value, tirn_pkg::DEST_CLIENT, 1'b0});
						end
						parser_state = PS_TEXT;
					end
					PS_DO: begin
						if (value != tirn_pkg::TELOPT_ECHO && value != tirn_pkg::OPT_SGA &&
						    value != tirn_pkg::OPT_BIN) begin
							burst.push_back('{tirn_pkg::B_IAC, tirn_pkg::DEST_CLIENT, 1'b0});
							burst.push_back('{tirn_pkg::B_WONT, tirn_pkg::DEST_CLIENT, 1'b0});
							burst.push_back('{value, tirn_pkg::DEST_CLIENT, 1'b0});
						end
						parser_state = PS_TEXT;
					end
					PS_WONT, PS_DONT: parser_state = PS_TEXT;
					PS_SUBNEG: begin
						if (value == tirn_pkg::B_IAC)
							parser_state = PS_SUBNEG_CMD;
					end
					default: parser_state = (value == tirn_pkg::B_SE) ? PS_TEXT : PS_SUBNEG;
				endcase
			end
			if (burst.size() > 0)
				burst[burst.size() - 1].last = 1'b1;
			foreach (burst[i])
				owed_bytes.push_back(burst[i]);
		endfunction

		function void check_emitted(logic [7:0] data, logic dest, logic last);
			emitted_t want;
			if (owed_bytes.size() == 0) begin
				$error("unexpected transfer: out_byte=%h out_dest=%b out_last=%b",
					data, dest, last);
				errors++;
				return;
			end
			want = owed_bytes.pop_front();
			if (data !== want.data) begin
				$error("out_byte: expected %h, actual %h", want.data, data);
				errors++;
			end
			if (dest !== want.dest) begin
				$error("out_dest: expected %b, actual %b", want.dest, dest);
				errors++;
			end
			if (last !== want.last) begin
				$error("out_last: expected %b, actual %b", want.last, last);
				errors++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n      = 1'b0;
	logic       cfg_wr_en   = 1'b0;
	logic       cfg_wr_data = 1'b0;
	logic       in_valid    = 1'b0;
	logic       in_ready;
	logic [1:0] kind        = tirn_pkg::KIND_BYTE;
	logic [7:0] rx_byte     = 8'h00;
	logic       out_valid;
	logic       out_ready   = 1'b0;
	logic [7:0] out_byte;
	logic       out_dest;
	logic       out_last;

	telnet_reply_scoreboard sb = new();

	// Idle and stall rates in percent, set per phase by the stimulus.
	int idle_pct  = 0;
	int stall_pct = 0;
	// Remaining cycles of a forced receiver hold-off.
	int hold_left = 0;
	// Counts accepted items that the block acts on.
	int items_sent = 0;
	int cycle_count = 0;

	telnet_iac_receive_negotiator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.out_dest    (out_dest),
		.out_last    (out_last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver side. A hold-off keeps ready low for a long stretch so the
	// result register fills and the input stalls; otherwise ready drops at
	// the phase's stall rate.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Both channels are sampled here at the edge, so values are the ones
	// that were stable before the edge. An input transfer is always noted
	// before the output transfer of the same edge, since the input is
	// registered and cannot produce a result in the cycle it enters.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.accept_item(kind, rx_byte);
			if (out_valid && out_ready)
				sb.check_emitted(out_byte, out_dest, out_last);
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Offers one item, after an optional random gap, and returns once it has
	// been transferred. Valid stays high on return so that a following item
	// can go out back to back; it is only lowered when a gap is taken.
	task automatic send_item(input logic [1:0] ev, input logic [7:0] value);
		int gap;
		gap = 0;
		while (gap < 20 && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind     <= ev;
		rx_byte  <= value;
		do
			@(posedge clk);
		while (!in_ready);
		if (ev != KIND_UNKNOWN)
			items_sent++;
	endtask

	task automatic send_negotiation(input logic [7:0] verb, input logic [7:0] opt);
		send_item(tirn_pkg::KIND_BYTE, tirn_pkg::B_IAC);
		send_item(tirn_pkg::KIND_BYTE, verb);
		send_item(tirn_pkg::KIND_BYTE, opt);
	endtask

	// Stops offering items, waits for every owed byte, then lets the block
	// finish any item that produces nothing.
	task automatic wait_quiet();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_delivery(input bit on);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= on;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_delivery(on);
	endtask

	// One random fragment of a client stream. Most fragments are well-formed
	// telnet sequences with random content so that every parser state is
	// reached; the rest are raw noise, cut-off commands and events.
	task automatic send_fragment();
		int pick;
		int len;
		logic [7:0] verb;
		logic [7:0] opt;
		pick = $urandom_range(99);
		if (pick < 25) begin
			send_item(tirn_pkg::KIND_BYTE, 8'($urandom_range(254)));
		end else if (pick < 33) begin
			// Doubled IAC, delivered as one data byte.
			send_item(tirn_pkg::KIND_BYTE, tirn_pkg::B_IAC);
			send_item(tirn_pkg::KIND_BYTE, tirn_pkg::B_IAC);
		end else if (pick < 63) begin
			case ($urandom_range(5))
				0, 1:    verb = tirn_pkg::B_WILL;
				2, 3:    verb = tirn_pkg::B_DO;
				4:       verb = tirn_pkg::B_WONT;
				default: verb = tirn_pkg::B_DONT;
			endcase
			// Favor the options that are accepted so both answers show up.
			case ($urandom_range(3))
				0:       opt = tirn_pkg::OPT_BIN;
				1:       opt = tirn_pkg::TELOPT_ECHO;
				2:       opt = tirn_pkg::OPT_SGA;
				default: opt = 8'($urandom_range(255));
			endcase
			send_negotiation(verb, opt);
		end else if (pick < 73) begin
			// Subnegotiation with a short random body, sometimes with an
			// escaped byte that must not end it.
			send_item(tirn_pkg::KIND_BYTE, tirn_pkg::B_IAC);
			send_item(tirn_pkg::KIND_BYTE, tirn_pkg::B_SB);
			len = $urandom_range(4);
			repeat (len) begin
				if ($urandom_range(3) == 0)
					send_item(tirn_pkg::KIND_BYTE, tirn_pkg::B_IAC);
				send_item(tirn_pkg::KIND_BYTE, 8'($urandom_range(255)));
			end
			send_item(tirn_pkg::KIND_BYTE, tirn_pkg::B_IAC);
			send_item(tirn_pkg::KIND_BYTE, tirn_pkg::B_SE);
		end else if (pick < 78) begin
			send_item(tirn_pkg::KIND_CONNECT, 8'($urandom_range(255)));
		end else if (pick < 82) begin
			send_item(tirn_pkg::KIND_DISCONNECT, 8'($urandom_range(255)));
		end else if (pick < 84) begin
			send_item(KIND_UNKNOWN, 8'($urandom_range(255)));
		end else if (pick < 94) begin
			send_item(tirn_pkg::KIND_BYTE, 8'($urandom_range(255)));
		end else begin
			// A command prefix followed by anything at all.
			send_item(tirn_pkg::KIND_BYTE, tirn_pkg::B_IAC);
			send_item(tirn_pkg::KIND_BYTE, 8'($urandom_range(255)));
		end
	endtask

	// One phase of random traffic under a fixed delivery setting and fixed
	// idle rates. The block is brought to rest before the register write.
	task automatic run_phase(input bit on, input int idle, input int stall,
			input int hold, input int count);
		int target;
		wait_quiet();
		write_delivery(on);
		idle_pct  = idle;
		stall_pct = stall;
		hold_left = hold;
		target    = items_sent + count;
		while (items_sent < target)
			send_fragment();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with delivery at its reset value of one and no
		// idling. A byte arrives before any connect, since the block keeps no
		// connection flag.
		send_item(tirn_pkg::KIND_BYTE, 8'h00);
		send_item(tirn_pkg::KIND_CONNECT, 8'h00);
		send_item(tirn_pkg::KIND_BYTE, 8'hFE);
		send_item(tirn_pkg::KIND_BYTE, tirn_pkg::B_IAC);
		send_item(tirn_pkg::KIND_BYTE, tirn_pkg::B_IAC);
		send_negotiation(tirn_pkg::B_WILL, tirn_pkg::OPT_BIN);
		send_negotiation(tirn_pkg::B_WILL, 8'hFF);
		send_negotiation(tirn_pkg::B_DO, tirn_pkg::TELOPT_ECHO);
		send_negotiation(tirn_pkg::B_DO, 8'h18);
		send_negotiation(tirn_pkg::B_WONT, tirn_pkg::OPT_SGA);
		// An unknown command after the prefix drops back to data.
		send_item(tirn_pkg::KIND_BYTE, tirn_pkg::B_IAC);
		send_item(tirn_pkg::KIND_BYTE, 8'hF1);
		// Subnegotiation where an escaped byte does not end it.
		send_item(tirn_pkg::KIND_BYTE, tirn_pkg::B_IAC);
		send_item(tirn_pkg::KIND_BYTE, tirn_pkg::B_SB);
		send_item(tirn_pkg::KIND_BYTE, tirn_pkg::B_IAC);
		send_item(tirn_pkg::KIND_BYTE, tirn_pkg::TELOPT_ECHO);
		send_item(tirn_pkg::KIND_BYTE, tirn_pkg::B_IAC);
		send_item(tirn_pkg::KIND_BYTE, tirn_pkg::B_SE);
		send_item(KIND_UNKNOWN, 8'hA5);
		// A disconnect in the middle of a command, then a repeated connect.
		send_item(tirn_pkg::KIND_BYTE, tirn_pkg::B_IAC);
		send_item(tirn_pkg::KIND_DISCONNECT, 8'hFF);
		send_item(tirn_pkg::KIND_CONNECT, 8'h5A);

		// Random phases. The hold-off phase keeps the sender busy while the
		// receiver is held, so the block fills up and stalls its input.
		run_phase(1'b1, 0, 0, 0, 75);
		run_phase(1'b0, 57, 0, 0, 75);
		run_phase(1'b1, 0, 57, 0, 75);
		run_phase(1'b0, 7, 7, 0, 75);
		run_phase(1'b1, 0, 0, HOLD_CYCLES, 75);

		wait_quiet();
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### sim.f
rtl/tirn_pkg.sv
rtl/tirn_parser.sv
rtl/tirn_emitter.sv
rtl/telnet_iac_receive_negotiator.sv
verif/testbench.sv
